### src/first_fit_heap_allocator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define FFHA_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("allocator invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define FFHA_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator sequencing violated");

`endif

### src/ffha_pkg.sv
// ---------------------------------------------------------------------------
// ffha_pkg
// Heap geometry, status codes, tag word helpers and the tag memory port type.
// ---------------------------------------------------------------------------
package ffha_pkg;

   localparam int HEAP_BYTES  = 1024;
   localparam int HEAP_USED   = HEAP_BYTES & 32'hFFFC;
   localparam int TAG_DEPTH   = HEAP_USED / 4 + 2;
   localparam int STORE_BYTES = TAG_DEPTH * 4;
   localparam int WALK_LIMIT  = 4 * TAG_DEPTH;
   localparam int IDX_W       = $clog2(TAG_DEPTH);
   localparam int BUD_W       = $clog2(WALK_LIMIT + 1);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_NOFIT = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [15:0]      wdata;
      logic [IDX_W-1:0] raddr;
   } tag_req_type;

   function automatic logic [15:0] t_size(input logic [15:0] v);
      t_size = {v[15:2], 2'b00};
   endfunction

   function automatic logic [15:0] t_pack(input logic [17:0] s, input logic a,
                                          input logic p);
      t_pack = {s[15:2], p, a};
   endfunction

   function automatic logic in_store(input logic [31:0] a);
      in_store = (a[1:0] == 2'b00) && (a < 32'(STORE_BYTES));
   endfunction

   function automatic logic [IDX_W-1:0] word_idx(input logic [31:0] a);
      word_idx = a[IDX_W+1:2];
   endfunction

   // Tag word contents after reset: prologue, one free block, epilogue.
   function automatic logic [15:0] init_word(input logic [IDX_W-1:0] idx);
      logic [15:0] blk;
      blk = t_pack(18'(HEAP_USED - 4), 1'b0, 1'b1);
      if (idx == '0) begin
         init_word = t_pack(18'd0, 1'b1, 1'b1);
      end else if (idx == IDX_W'(1) || idx == IDX_W'(HEAP_USED / 4)) begin
         init_word = blk;
      end else if (idx == IDX_W'(TAG_DEPTH - 1)) begin
         init_word = t_pack(18'd0, 1'b1, 1'b0);
      end else begin
         init_word = 16'h0000;
      end
   endfunction

endpackage

### src/first_fit_heap_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an implicit list of boundary-tagged heap blocks.
// ---------------------------------------------------------------------------
// A request on the req_ channel either allocates (req_action 0, req_bytes
// payload bytes) or frees (req_action 1, req_free_offset as returned by an
// earlier allocate). Each request produces exactly one response on the rsp_
// channel carrying rsp_status and rsp_payload_offset.
// All tag words live in one synchronous memory with a registered read.
// A free passes through S_FR0 to S_FR3 and, when the following block is
// free, S_FR4 to write its footer before S_RESP presents the response.
// An allocate walks the block list from the heap start, merging free runs
// on the way; it reads the prologue to find the first block, then the
// header of each block visited and its neighbors for each merge, and last
// splits and marks the winner, so its latency grows with fragmentation.
// One request is in work at a time. A new request can be accepted while the
// previous response still sits in the output register.
// After reset the block writes the initial prologue, free block and
// epilogue into all TAG_DEPTH (258) words of the memory; req_ready stays low
// during that pass. If the receiver holds rsp_ready low, the finished request
// waits in its final state until the output register is free.
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [15:0] req_bytes,
   input  logic [10:0] req_free_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_payload_offset
);

   localparam int IW = ffha_pkg::IDX_W;
   localparam int BW = ffha_pkg::BUD_W;

   typedef enum logic [23:0] {
      S_INIT = 24'h000001,
      S_IDLE = 24'h000002,
      S_FF0  = 24'h000004,
      S_FF1  = 24'h000008,
      S_FFT  = 24'h000010,
      S_FFH  = 24'h000020,
      S_COT  = 24'h000040,
      S_COH  = 24'h000080,
      S_COF  = 24'h000100,
      S_CON  = 24'h000200,
      S_COW  = 24'h000400,
      S_COW2 = 24'h000800,
      S_AL1  = 24'h001000,
      S_AL2  = 24'h002000,
      S_AL3  = 24'h004000,
      S_AL4  = 24'h008000,
      S_AL5  = 24'h010000,
      S_FR0  = 24'h020000,
      S_FR1  = 24'h040000,
      S_FR2  = 24'h080000,
      S_FR3  = 24'h100000,
      S_FR4  = 24'h200000,
      S_RESP = 24'h400000
   } state_type;

   state_type   state_ff, state_in;
   logic [IW-1:0] init_ff, init_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] loc_ff, loc_in;
   logic [BW-1:0] bud_ff, bud_in;
   logic        chg_ff, chg_in;
   logic [15:0] fh_ff, fh_in;
   logic [15:0] hv_ff, hv_in;
   logic [17:0] size_ff, size_in;
   logic [17:0] keep_ff, keep_in;
   logic        oob_ff, oob_in;
   logic [1:0]  st_ff, st_in;
   logic [10:0] po_ff, po_in;
   logic        rv_ff, rv_in;
   logic [1:0]  ost_ff, ost_in;
   logic [10:0] opo_ff, opo_in;

   ffha_pkg::tag_req_type tag_req;
   logic [15:0] ram_q;
   logic [15:0] d;
   logic [31:0] rd_addr;
   logic [31:0] wr_addr;
   logic [15:0] wr_data;
   logic        wr_en;
   logic [31:0] step_cur;
   logic [17:0] diff;
   logic [17:0] rsz;
   logic [17:0] rnd;

   ffha_tag_ram u_ram (
      .clock   (clock),
      .tag_req (tag_req),
      .rdata   (ram_q)
   );

   // Reads outside the store behave as an epilogue word.
   assign d = oob_ff ? 16'h0001 : ram_q;

   // Where a coalesce pass returns to the walk: stay if anything moved,
   // otherwise step past the block the walk last looked at.
   assign step_cur = chg_ff ? cur_ff : cur_ff + {16'h0, ffha_pkg::t_size(fh_ff)} + 32'd4;

   assign diff = {2'b00, ffha_pkg::t_size(fh_ff)} - size_ff;
   assign rsz  = {2'b00, ffha_pkg::t_size(fh_ff)} - keep_ff - 18'd4;
   assign rnd  = ({2'b00, req_bytes} + 18'd3) & ~18'd3;

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      cur_in   = cur_ff;
      loc_in   = loc_ff;
      bud_in   = bud_ff;
      chg_in   = chg_ff;
      fh_in    = fh_ff;
      hv_in    = hv_ff;
      size_in  = size_ff;
      keep_in  = keep_ff;
      st_in    = st_ff;
      po_in    = po_ff;
      rv_in    = rv_ff;
      ost_in   = ost_ff;
      opo_in   = opo_ff;
      rd_addr  = cur_ff;
      wr_addr  = cur_ff;
      wr_data  = hv_ff;
      wr_en    = 1'b0;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            init_in = init_ff + IW'(1);
            if (init_ff == IW'(ffha_pkg::TAG_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               st_in = ffha_pkg::ST_OK;
               po_in = 11'd0;
               if (req_action == ffha_pkg::ACT_FREE) begin
                  cur_in = {21'h0, req_free_offset} - 32'd4;
                  if (req_free_offset >= 11'd4 && req_free_offset[1:0] == 2'b00 &&
                      ({21'h0, req_free_offset} - 32'd4) < 32'(ffha_pkg::STORE_BYTES)) begin
                     state_in = S_FR0;
                  end else begin
                     state_in = S_RESP;
                  end
               end else if (req_bytes == 16'd0) begin
                  st_in    = ffha_pkg::ST_ZERO;
                  state_in = S_RESP;
               end else begin
                  size_in  = rnd;
                  state_in = S_FF0;
               end
            end
         end
         S_FF0: begin
            rd_addr  = 32'd0;
            state_in = S_FF1;
         end
         S_FF1: begin
            cur_in   = {16'h0, ffha_pkg::t_size(d)} + 32'd4;
            bud_in   = BW'(ffha_pkg::WALK_LIMIT);
            state_in = S_FFT;
         end
         S_FFT: begin
            if (bud_ff == '0) begin
               st_in    = ffha_pkg::ST_NOFIT;
               state_in = S_RESP;
            end else begin
               bud_in   = bud_ff - BW'(1);
               rd_addr  = cur_ff;
               state_in = S_FFH;
            end
         end
         S_FFH: begin
            fh_in = d;
            if (!d[0] && {2'b00, ffha_pkg::t_size(d)} >= size_ff + 18'd4) begin
               loc_in   = cur_ff;
               state_in = S_AL1;
            end else if (ffha_pkg::t_size(d) == 16'd0 && d[0]) begin
               st_in    = ffha_pkg::ST_NOFIT;
               state_in = S_RESP;
            end else begin
               chg_in   = 1'b0;
               state_in = S_COT;
            end
         end
         S_COT: begin
            if (bud_ff == '0) begin
               cur_in   = step_cur;
               state_in = S_FFT;
            end else begin
               bud_in   = bud_ff - BW'(1);
               rd_addr  = cur_ff;
               state_in = S_COH;
            end
         end
         S_COH: begin
            hv_in = d;
            if (d[0]) begin
               cur_in   = step_cur;
               state_in = S_FFT;
            end else if (!d[1]) begin
               rd_addr  = cur_ff - 32'd4;
               state_in = S_COF;
            end else begin
               rd_addr  = cur_ff + {16'h0, ffha_pkg::t_size(d)} + 32'd4;
               state_in = S_CON;
            end
         end
         S_COF: begin
            cur_in   = cur_ff - {16'h0, ffha_pkg::t_size(d)} - 32'd4;
            chg_in   = 1'b1;
            state_in = S_COT;
         end
         S_CON: begin
            if (!d[0]) begin
               hv_in = ffha_pkg::t_pack({2'b00, ffha_pkg::t_size(hv_ff)} +
                                        {2'b00, ffha_pkg::t_size(d)} + 18'd4, 1'b0, 1'b1);
               state_in = S_COW;
            end else begin
               cur_in   = step_cur;
               state_in = S_FFT;
            end
         end
         S_COW: begin
            wr_en    = 1'b1;
            state_in = S_COW2;
         end
         S_COW2: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff + {16'h0, ffha_pkg::t_size(hv_ff)};
            chg_in   = 1'b1;
            state_in = S_COT;
         end
         S_AL1: begin
            // The block keeps its whole size when the remainder is too small.
            keep_in  = (diff < 18'd8) ? {2'b00, ffha_pkg::t_size(fh_ff)} : size_ff;
            state_in = (diff < 18'd8) ? S_AL3 : S_AL2;
         end
         S_AL2: begin
            wr_en    = 1'b1;
            wr_addr  = loc_ff + {14'h0, keep_ff} + 32'd4;
            wr_data  = ffha_pkg::t_pack(rsz, 1'b0, 1'b0);
            hv_in    = ffha_pkg::t_pack(rsz, 1'b0, 1'b0);
            cur_in   = loc_ff + {14'h0, keep_ff} + 32'd4 +
                       {16'h0, ffha_pkg::t_size(ffha_pkg::t_pack(rsz, 1'b0, 1'b0))};
            state_in = S_FR4;
         end
         S_FR4: begin
            // Footer write, shared by split remainder and free neighbor.
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            state_in = (st_ff == ffha_pkg::ST_OK && loc_ff != 32'hFFFF_FFFF &&
                        fh_ff[0] == 1'b0) ? S_AL3 : S_RESP;
         end
         S_AL3: begin
            wr_en    = 1'b1;
            wr_addr  = loc_ff;
            wr_data  = ffha_pkg::t_pack(keep_ff, 1'b1, fh_ff[1]);
            fh_in    = {fh_ff[15:1], 1'b1};
            state_in = S_AL4;
         end
         S_AL4: begin
            rd_addr  = loc_ff + {14'h0, keep_ff} + 32'd4;
            state_in = S_AL5;
         end
         S_AL5: begin
            wr_en    = 1'b1;
            wr_addr  = loc_ff + {14'h0, keep_ff} + 32'd4;
            wr_data  = ffha_pkg::t_pack({2'b00, ffha_pkg::t_size(d)}, d[0], 1'b1);
            st_in    = ffha_pkg::ST_OK;
            po_in    = 11'(loc_ff + 32'd4);
            state_in = S_RESP;
         end
         S_FR0: begin
            rd_addr  = cur_ff;
            fh_in    = 16'h0001;
            state_in = S_FR1;
         end
         S_FR1: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = ffha_pkg::t_pack({2'b00, ffha_pkg::t_size(d)}, 1'b0, d[1]);
            hv_in    = ffha_pkg::t_pack({2'b00, ffha_pkg::t_size(d)}, 1'b0, d[1]);
            state_in = S_FR2;
         end
         S_FR2: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff + {16'h0, ffha_pkg::t_size(hv_ff)};
            rd_addr  = cur_ff + {16'h0, ffha_pkg::t_size(hv_ff)} + 32'd4;
            loc_in   = cur_ff + {16'h0, ffha_pkg::t_size(hv_ff)} + 32'd4;
            state_in = S_FR3;
         end
         S_FR3: begin
            wr_en    = 1'b1;
            wr_addr  = loc_ff;
            wr_data  = ffha_pkg::t_pack({2'b00, ffha_pkg::t_size(d)}, d[0], 1'b0);
            hv_in    = ffha_pkg::t_pack({2'b00, ffha_pkg::t_size(d)}, d[0], 1'b0);
            cur_in   = loc_ff + {16'h0, ffha_pkg::t_size(d)};
            // An out-of-store neighbor reads as allocated and needs no footer.
            state_in = d[0] ? S_RESP : S_FR4;
         end
         S_RESP: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               ost_in   = st_ff;
               opo_in   = po_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   assign oob_in = !ffha_pkg::in_store(rd_addr);

   always_comb begin
      tag_req.raddr = ffha_pkg::word_idx(rd_addr);
      if (state_ff == S_INIT) begin
         tag_req.we    = 1'b1;
         tag_req.waddr = init_ff;
         tag_req.wdata = ffha_pkg::init_word(init_ff);
      end else begin
         tag_req.we    = wr_en && ffha_pkg::in_store(wr_addr);
         tag_req.waddr = ffha_pkg::word_idx(wr_addr);
         tag_req.wdata = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff  <= '0;
         rv_ff    <= 1'b0;
         bud_ff   <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         rv_ff    <= rv_in;
         bud_ff   <= bud_in;
      end
      cur_ff  <= cur_in;
      loc_ff  <= loc_in;
      chg_ff  <= chg_in;
      fh_ff   <= fh_in;
      hv_ff   <= hv_in;
      size_ff <= size_in;
      keep_ff <= keep_in;
      oob_ff  <= oob_in;
      st_ff   <= st_in;
      po_ff   <= po_in;
      ost_ff  <= ost_in;
      opo_ff  <= opo_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rv_ff;
   assign rsp_status         = ost_ff;
   assign rsp_payload_offset = opo_ff;

   `FFHA_ALWAYS(a_idle_no_write, (state_ff != S_IDLE) || !tag_req.we)
   `FFHA_NEXT(a_rsp_from_final, !rv_ff && (state_ff != S_RESP), !rv_ff)
   `FFHA_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != S_IDLE)
   `FFHA_ALWAYS(a_budget_bound, bud_ff <= BW'(ffha_pkg::WALK_LIMIT) || state_ff == S_IDLE ||
                state_ff == S_INIT || state_ff == S_FF0 || state_ff == S_FF1)

endmodule

### src/ffha_tag_ram.sv
// ---------------------------------------------------------------------------
// ffha_tag_ram
// Single-port-write, single-port-read tag word store with registered read.
// ---------------------------------------------------------------------------
module ffha_tag_ram (
   input  logic                    clock,
   input  ffha_pkg::tag_req_type   tag_req,
   output logic [15:0]             rdata
);

   logic [15:0] mem [ffha_pkg::TAG_DEPTH];

   always_ff @(posedge clock) begin
      if (tag_req.we) begin
         mem[tag_req.waddr] <= tag_req.wdata;
      end
      rdata <= mem[tag_req.raddr];
   end

endmodule
